@@ hw/rtl/resp3_pkg.sv @@
// resp3_pkg: shared types and codes for the resp3 stream parser
// no dependencies; used by resp3_core and resp3_stream_parser
package resp3_pkg;

    localparam int LEN_BITS   = 32;
    localparam int COUNT_BITS = 32;
    localparam int LEFT_BITS  = COUNT_BITS + 2;

    // event kinds
    localparam logic [1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [1:0] EV_COMPLETE = 2'd1;
    localparam logic [1:0] EV_ERROR    = 2'd2;

    // one result beat
    typedef struct packed {
        logic [1:0]         event_kind;
        logic [7:0]         payload_byte;
        logic               is_encoding;
        logic [3:0]         element_type;
        logic signed [63:0] element_value;
        logic               is_null;
        logic               message_done;
    } result_t;

endpackage

@@ hw/rtl/resp3_core.sv @@
// resp3_core: per-byte parser state and result generation
// depends on resp3_pkg
module resp3_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    output logic                res_valid,
    output resp3_pkg::result_t  res
);

    // parser phases
    localparam logic [3:0] PH_TYPE = 4'd0;
    localparam logic [3:0] PH_TEXT = 4'd1;
    localparam logic [3:0] PH_NUM  = 4'd2;
    localparam logic [3:0] PH_NULL = 4'd3;
    localparam logic [3:0] PH_BOOL = 4'd4;
    localparam logic [3:0] PH_DATA = 4'd5;
    localparam logic [3:0] PH_TCR  = 4'd6;
    localparam logic [3:0] PH_TLF  = 4'd7;

    // element types
    localparam logic [3:0] T_SIMPLE = 4'd0;
    localparam logic [3:0] T_ERR    = 4'd1;
    localparam logic [3:0] T_INT    = 4'd2;
    localparam logic [3:0] T_NULL   = 4'd3;
    localparam logic [3:0] T_BOOL   = 4'd4;
    localparam logic [3:0] T_DOUBLE = 4'd5;
    localparam logic [3:0] T_BIGNUM = 4'd6;
    localparam logic [3:0] T_BULK   = 4'd7;
    localparam logic [3:0] T_BLKERR = 4'd8;
    localparam logic [3:0] T_VERB   = 4'd9;
    localparam logic [3:0] T_ARRAY  = 4'd10;
    localparam logic [3:0] T_SET    = 4'd11;
    localparam logic [3:0] T_PUSH   = 4'd12;
    localparam logic [3:0] T_MAP    = 4'd13;
    localparam logic [3:0] T_ATTR   = 4'd14;
    localparam logic [3:0] T_BAD    = 4'd15;

    localparam logic [63:0] SAT_LIM = 64'd922337203685477580;
    localparam logic [63:0] TOP_BIT = {1'b1, 63'd0};

    logic [3:0]                     phase_reg, phase_next;
    logic [3:0]                     type_reg, type_next;
    logic                           cr_reg, cr_next;
    logic [63:0]                    acc_reg, acc_next;
    logic                           neg_reg, neg_next;
    logic [1:0]                     lb_reg, lb_next;
    logic [resp3_pkg::LEN_BITS-1:0] bulk_reg, bulk_next;
    logic [2:0]                     vi_reg, vi_next;
    logic [resp3_pkg::LEFT_BITS-1:0] left_reg, left_next;
    logic                           failed_reg, failed_next;

    // type byte decode
    function automatic logic [3:0] type_of(input logic [7:0] b);
        case (b)
            8'h2B:   type_of = T_SIMPLE;
            8'h2D:   type_of = T_ERR;
            8'h3A:   type_of = T_INT;
            8'h5F:   type_of = T_NULL;
            8'h23:   type_of = T_BOOL;
            8'h2C:   type_of = T_DOUBLE;
            8'h28:   type_of = T_BIGNUM;
            8'h24:   type_of = T_BULK;
            8'h21:   type_of = T_BLKERR;
            8'h3D:   type_of = T_VERB;
            8'h2A:   type_of = T_ARRAY;
            8'h7E:   type_of = T_SET;
            8'h3E:   type_of = T_PUSH;
            8'h25:   type_of = T_MAP;
            8'h7C:   type_of = T_ATTR;
            default: type_of = T_BAD;
        endcase
    endfunction

    // next state and result for the accepted byte
    always_comb
    begin
        logic                            do_fail;
        logic                            do_cmp;
        logic                            do_pay;
        logic                            enc;
        logic [63:0]                     cval;
        logic                            cnull;
        logic [resp3_pkg::LEFT_BITS-1:0] cadd;
        logic [resp3_pkg::LEFT_BITS-1:0] left;
        logic [resp3_pkg::LEFT_BITS:0]   sum;
        logic                            done;
        logic [3:0]                      t;
        logic [63:0]                     lim;
        logic [63:0]                     dig;
        logic [resp3_pkg::LEN_BITS-1:0]  bdec;

        phase_next  = phase_reg;
        type_next   = type_reg;
        cr_next     = cr_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        lb_next     = lb_reg;
        bulk_next   = bulk_reg;
        vi_next     = vi_reg;
        left_next   = left_reg;
        failed_next = failed_reg;
        do_fail = 1'b0;
        do_cmp  = 1'b0;
        do_pay  = 1'b0;
        enc     = 1'b0;
        cval    = 64'd0;
        cnull   = 1'b0;
        cadd    = '0;
        left    = left_reg;
        sum     = '0;
        done    = 1'b0;
        t       = type_of(data_byte);
        dig     = {60'd0, data_byte[3:0]};
        lim     = (data_byte == 8'h39) ? SAT_LIM - 64'd1 : SAT_LIM;
        bdec    = bulk_reg;

        case (phase_reg)
            PH_TEXT, PH_NUM, PH_NULL, PH_BOOL:
            begin
                if (cr_reg)
                begin
                    cr_next = 1'b0;
                    if (data_byte != 8'h0A)
                        do_fail = 1'b1;
                    else if (phase_reg == PH_TEXT)
                    begin
                        if (type_reg == T_DOUBLE && acc_reg == 64'd0)
                            do_fail = 1'b1;
                        else
                        begin
                            do_cmp = 1'b1;
                            cval   = acc_reg;
                        end
                    end
                    else if (phase_reg == PH_NULL)
                    begin
                        do_cmp = 1'b1;
                        cnull  = 1'b1;
                    end
                    else if (phase_reg == PH_BOOL)
                    begin
                        if (lb_reg == 2'd0)
                            do_fail = 1'b1;
                        else
                        begin
                            do_cmp = 1'b1;
                            cval   = acc_reg;
                        end
                    end
                    else if (lb_reg != 2'd2)
                        do_fail = 1'b1;
                    else if (type_reg <= T_BIGNUM)
                    begin
                        do_cmp = 1'b1;
                        if (neg_reg)
                            cval = 64'd0 - acc_reg;
                        else
                            cval = (acc_reg >= TOP_BIT) ? TOP_BIT - 64'd1 : acc_reg;
                    end
                    else if (neg_reg && acc_reg != 64'd0)
                    begin
                        if (acc_reg != 64'd1)
                            do_fail = 1'b1;
                        else
                        begin
                            do_cmp = 1'b1;
                            cval   = '1;
                            cnull  = 1'b1;
                        end
                    end
                    else if (type_reg <= T_VERB)
                    begin
                        if (|acc_reg[63:resp3_pkg::LEN_BITS])
                            do_fail = 1'b1;
                        else if (type_reg == T_VERB && acc_reg < 64'd4)
                            do_fail = 1'b1;
                        else
                        begin
                            bulk_next  = acc_reg[resp3_pkg::LEN_BITS-1:0];
                            phase_next = (acc_reg == 64'd0) ? PH_TCR : PH_DATA;
                        end
                    end
                    else if (|acc_reg[63:resp3_pkg::COUNT_BITS])
                        do_fail = 1'b1;
                    else
                    begin
                        do_cmp = 1'b1;
                        cval   = acc_reg;
                        if (type_reg == T_MAP || type_reg == T_ATTR)
                            cadd = {1'b0, acc_reg[resp3_pkg::COUNT_BITS-1:0], 1'b0};
                        else
                            cadd = {2'b00, acc_reg[resp3_pkg::COUNT_BITS-1:0]};
                    end
                end
                else if (data_byte == 8'h0D)
                    cr_next = 1'b1;
                else if (phase_reg == PH_TEXT)
                begin
                    if (acc_reg != '1)
                        acc_next = acc_reg + 64'd1;
                    do_pay = 1'b1;
                end
                else if (phase_reg == PH_NUM)
                begin
                    if ((data_byte == 8'h2B || data_byte == 8'h2D) && lb_reg == 2'd0)
                    begin
                        neg_next = (data_byte == 8'h2D);
                        lb_next  = 2'd1;
                    end
                    else if (data_byte >= 8'h30 && data_byte <= 8'h39)
                    begin
                        if (acc_reg > lim)
                            acc_next = TOP_BIT;
                        else
                            acc_next = (acc_reg << 3) + (acc_reg << 1) + dig;
                        lb_next = 2'd2;
                    end
                    else
                        do_fail = 1'b1;
                end
                else if (phase_reg == PH_BOOL && lb_reg == 2'd0 &&
                         (data_byte == 8'h74 || data_byte == 8'h54 ||
                          data_byte == 8'h66 || data_byte == 8'h46))
                begin
                    acc_next = (data_byte == 8'h74 || data_byte == 8'h54) ? 64'd1 : 64'd0;
                    lb_next  = 2'd1;
                end
                else
                    do_fail = 1'b1;
            end
            PH_DATA:
            begin
                if (bulk_reg != '0)
                    bdec = bulk_reg - 1'b1;
                bulk_next = bdec;
                if (bdec == '0)
                    phase_next = PH_TCR;
                if (type_reg == T_VERB && vi_reg < 3'd4)
                begin
                    if (vi_reg < 3'd3)
                    begin
                        vi_next = vi_reg + 3'd1;
                        do_pay  = 1'b1;
                        enc     = 1'b1;
                    end
                    else if (data_byte != 8'h3A)
                        do_fail = 1'b1;
                    else
                        vi_next = 3'd4;
                end
                else
                    do_pay = 1'b1;
            end
            PH_TCR:
            begin
                if (data_byte != 8'h0D)
                    do_fail = 1'b1;
                else
                    phase_next = PH_TLF;
            end
            PH_TLF:
            begin
                if (data_byte != 8'h0A)
                    do_fail = 1'b1;
                else
                begin
                    do_cmp = 1'b1;
                    cval   = (type_reg == T_VERB) ? acc_reg - 64'd4 : acc_reg;
                end
            end
            default:
            begin
                cr_next   = 1'b0;
                acc_next  = 64'd0;
                neg_next  = 1'b0;
                lb_next   = 2'd0;
                bulk_next = '0;
                vi_next   = 3'd0;
                if (t == T_BAD)
                begin
                    type_next = T_SIMPLE;
                    do_fail   = 1'b1;
                end
                else
                begin
                    type_next = t;
                    if (t == T_SIMPLE || t == T_ERR || t == T_DOUBLE)
                        phase_next = PH_TEXT;
                    else if (t == T_NULL)
                        phase_next = PH_NULL;
                    else if (t == T_BOOL)
                        phase_next = PH_BOOL;
                    else
                        phase_next = PH_NUM;
                end
            end
        endcase

        // element completion: outstanding element count
        if (do_cmp)
        begin
            if (type_reg != T_ATTR && left != '0)
                left = left - 1'b1;
            sum = {1'b0, left} + {1'b0, cadd};
            if (sum[resp3_pkg::LEFT_BITS])
                do_fail = 1'b1;
            else
            begin
                left = sum[resp3_pkg::LEFT_BITS-1:0];
                if (left == '0)
                begin
                    done = 1'b1;
                    left = {{(resp3_pkg::LEFT_BITS-1){1'b0}}, 1'b1};
                end
                left_next  = left;
                phase_next = PH_TYPE;
            end
        end

        res_valid                = 1'b0;
        res.event_kind           = resp3_pkg::EV_PAYLOAD;
        res.payload_byte         = 8'd0;
        res.is_encoding          = 1'b0;
        res.element_type         = type_next;
        res.element_value        = 64'sd0;
        res.is_null              = 1'b0;
        res.message_done         = 1'b0;
        if (do_fail)
        begin
            failed_next    = 1'b1;
            res_valid      = 1'b1;
            res.event_kind = resp3_pkg::EV_ERROR;
        end
        else if (do_cmp)
        begin
            res_valid         = 1'b1;
            res.event_kind    = resp3_pkg::EV_COMPLETE;
            res.element_value = cval;
            res.is_null       = cnull;
            res.message_done  = done;
        end
        else if (do_pay)
        begin
            res_valid        = 1'b1;
            res.payload_byte = data_byte;
            res.is_encoding  = enc;
        end

        // silent after an error or when no byte is accepted
        if (failed_reg || !accept)
            res_valid = 1'b0;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            type_reg   <= T_SIMPLE;
            cr_reg     <= 1'b0;
            acc_reg    <= 64'd0;
            neg_reg    <= 1'b0;
            lb_reg     <= 2'd0;
            bulk_reg   <= '0;
            vi_reg     <= 3'd0;
            left_reg   <= {{(resp3_pkg::LEFT_BITS-1){1'b0}}, 1'b1};
            failed_reg <= 1'b0;
        end
        else if (accept && !failed_reg)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            cr_reg     <= cr_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            lb_reg     <= lb_next;
            bulk_reg   <= bulk_next;
            vi_reg     <= vi_next;
            left_reg   <= left_next;
            failed_reg <= failed_next;
        end
    end

endmodule

@@ hw/rtl/resp3_stream_parser.sv @@
// resp3_stream_parser: RESP3 byte stream parser, top level
// depends on resp3_pkg and resp3_core
//
// Input channel: one stream byte per beat on data_byte, in_valid/in_stall.
// Output channel: zero or one result beat per input byte, out_valid/out_stall,
// carrying event_kind (payload byte, element complete, protocol error) and the
// element fields.
// Results are registered: each goes to the output register, or to the skid
// register while the receiver stalls. Throughput: one byte per cycle while
// in_stall is low; the parser state is updated in the same cycle the byte is
// accepted. A one-entry skid register behind the output register lets the
// input keep flowing while the receiver stalls, until one result beat waits
// there; in_stall rises only when the skid entry is full.
// Reset: parser waits for a type byte, outstanding element count is one,
// both output registers are empty. After a protocol error result the block
// takes bytes but produces no further results until reset.
module resp3_stream_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         event_kind,
    output logic [7:0]         payload_byte,
    output logic               is_encoding,
    output logic [3:0]         element_type,
    output logic signed [63:0] element_value,
    output logic               is_null,
    output logic               message_done
);

    logic               accept;
    logic               res_valid;
    resp3_pkg::result_t res;
    logic               out_vld_reg;
    logic               skid_vld_reg;
    resp3_pkg::result_t out_res_reg;
    resp3_pkg::result_t skid_res_reg;
    logic               out_free;

    assign in_stall = skid_vld_reg;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_vld_reg || !out_stall;

    resp3_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // output and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg  <= skid_vld_reg || res_valid;
            skid_vld_reg <= 1'b0;
        end
        else if (res_valid)
            skid_vld_reg <= 1'b1;
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_vld_reg)
                out_res_reg <= skid_res_reg;
            else if (res_valid)
                out_res_reg <= res;
        end
        else if (res_valid)
            skid_res_reg <= res;
    end

    assign out_valid     = out_vld_reg;
    assign event_kind    = out_res_reg.event_kind;
    assign payload_byte  = out_res_reg.payload_byte;
    assign is_encoding   = out_res_reg.is_encoding;
    assign element_type  = out_res_reg.element_type;
    assign element_value = out_res_reg.element_value;
    assign is_null       = out_res_reg.is_null;
    assign message_done  = out_res_reg.message_done;

    // skid entry only holds a beat behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry valid with empty output register");

    // nothing follows an error result from the parser
    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.event_kind == resp3_pkg::EV_ERROR) |=> !res_valid)
        else $error("result produced after protocol error");

    // message completion only on an element complete beat
    a_done_on_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && message_done) |-> event_kind == resp3_pkg::EV_COMPLETE)
        else $error("message_done on a non-complete beat");

    // a held output beat is not overwritten
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_stall) |=> (out_vld_reg && $stable(out_res_reg)))
        else $error("output beat changed while stalled");

endmodule

@@ dv/resp3_stream_parser_tb.sv @@
// resp3_stream_parser_tb: self-checking testbench for the resp3 stream parser
// depends on resp3_pkg and resp3_stream_parser; predicts every result beat
// from a local parser model and checks each output beat in order
module resp3_stream_parser_tb;

    localparam int LIMIT_CYCLES = 600000;
    localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LEFT_MAX = (64'd1 << resp3_pkg::LEFT_BITS) - 64'd1;
    localparam string TYPE_CHARS = "+-:_#,($!=*~>%|";
    localparam string BOOL_CHARS = "tTfF";

    typedef enum logic [3:0] {
        PH_TYPE, PH_TEXT, PH_NUM, PH_NULL, PH_BOOL, PH_DATA, PH_TCR, PH_TLF
    } phase_e;

    typedef enum logic [3:0] {
        TY_SIMPLE, TY_ERROR, TY_INT, TY_NULL, TY_BOOL, TY_DOUBLE, TY_BIGNUM,
        TY_BULK, TY_BULKERR, TY_VERB, TY_ARRAY, TY_SET, TY_PUSH, TY_MAP,
        TY_ATTR, TY_BAD
    } etype_e;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = 8'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         event_kind;
    logic [7:0]         payload_byte;
    logic               is_encoding;
    logic [3:0]         element_type;
    logic signed [63:0] element_value;
    logic               is_null;
    logic               message_done;

    resp3_stream_parser u_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // parser model state
    phase_e      ph = PH_TYPE;
    logic [3:0]  typ = 4'd0;
    bit          cr_seen, negative, failed;
    logic [63:0] acc = 64'd0;
    int unsigned line_bytes, verb_idx;
    logic [63:0] bulk_left = 64'd0;
    logic [63:0] elem_left = 64'd1;

    logic [7:0]         byte_q[$];
    resp3_pkg::result_t expect_q[$];
    int         errors = 0;
    int         cycles = 0;
    bit         calm = 1'b0;
    bit         long_hold = 1'b0;
    bit         send_pause = 1'b0;
    int         send_gap = 0;
    int         recv_gap = 0;

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic resp3_pkg::result_t make_res(input logic [1:0] kind,
                                                    input logic [7:0] pay,
                                                    input bit enc, input logic [63:0] val,
                                                    input bit nul, input bit done);
        resp3_pkg::result_t r;
        r.event_kind    = kind;
        r.payload_byte  = pay;
        r.is_encoding   = enc;
        r.element_type  = typ;
        r.element_value = val;
        r.is_null       = nul;
        r.message_done  = done;
        return r;
    endfunction

    function automatic bit fail_res(output resp3_pkg::result_t r);
        failed = 1'b1;
        r = make_res(resp3_pkg::EV_ERROR, 8'd0, 1'b0, 64'd0, 1'b0, 1'b0);
        return 1'b1;
    endfunction

    // element done: update outstanding count, flag end of message
    function automatic bit finish_elem(input logic [63:0] val, input bit nul,
                                       input logic [63:0] add,
                                       output resp3_pkg::result_t r);
        logic [63:0] left;
        bit done;
        left = elem_left;
        done = 1'b0;
        if (typ != TY_ATTR && left > 0)
            left--;
        if (left > LEFT_MAX || add > LEFT_MAX - left)
            return fail_res(r);
        left += add;
        if (left == 0)
        begin
            done = 1'b1;
            left = 64'd1;
        end
        elem_left = left;
        ph = PH_TYPE;
        r = make_res(resp3_pkg::EV_COMPLETE, 8'd0, 1'b0, val, nul, done);
        return 1'b1;
    endfunction

    function automatic bit end_of_line(output resp3_pkg::result_t r);
        logic [63:0] val;
        r = '0;
        cr_seen = 1'b0;
        if (ph == PH_TEXT)
        begin
            if (typ == TY_DOUBLE && acc == 0)
                return fail_res(r);
            return finish_elem(acc, 1'b0, 64'd0, r);
        end
        if (ph == PH_NULL)
            return finish_elem(64'd0, 1'b1, 64'd0, r);
        if (ph == PH_BOOL)
        begin
            if (line_bytes == 0)
                return fail_res(r);
            return finish_elem(acc, 1'b0, 64'd0, r);
        end
        if (line_bytes != 2)
            return fail_res(r);
        if (typ <= TY_BIGNUM)
        begin
            if (negative)
                val = 64'd0 - acc;
            else
                val = (acc >= TOP_BIT) ? TOP_BIT - 64'd1 : acc;
            return finish_elem(val, 1'b0, 64'd0, r);
        end
        if (negative && acc != 0)
        begin
            if (acc != 1)
                return fail_res(r);
            return finish_elem('1, 1'b1, 64'd0, r);
        end
        if (typ <= TY_VERB)
        begin
            if (acc > (64'd1 << resp3_pkg::LEN_BITS) - 64'd1)
                return fail_res(r);
            if (typ == TY_VERB && acc < 4)
                return fail_res(r);
            bulk_left = acc;
            ph = (acc == 0) ? PH_TCR : PH_DATA;
            return 1'b0;
        end
        if (acc > (64'd1 << resp3_pkg::COUNT_BITS) - 64'd1)
            return fail_res(r);
        val = (typ == TY_MAP || typ == TY_ATTR) ? acc << 1 : acc;
        return finish_elem(acc, 1'b0, val, r);
    endfunction

    function automatic logic [3:0] type_code_of(input logic [7:0] b);
        for (int i = 0; i < 15; i++)
            if (TYPE_CHARS[i] == b)
                return i[3:0];
        return TY_BAD;
    endfunction

    // one accepted stream byte; returns 1 when a result beat is due
    function automatic bit predict_beat(input logic [7:0] b, output resp3_pkg::result_t r);
        logic [63:0] d;
        logic [3:0]  t;
        r = '0;
        if (failed)
            return 1'b0;
        case (ph)
            PH_TEXT, PH_NUM, PH_NULL, PH_BOOL:
            begin
                if (cr_seen)
                begin
                    if (b == 8'h0A)
                        return end_of_line(r);
                    return fail_res(r);
                end
                if (b == 8'h0D)
                begin
                    cr_seen = 1'b1;
                    return 1'b0;
                end
                if (ph == PH_TEXT)
                begin
                    if (acc != '1)
                        acc++;
                    r = make_res(resp3_pkg::EV_PAYLOAD, b, 1'b0, 64'd0, 1'b0, 1'b0);
                    return 1'b1;
                end
                if (ph == PH_NUM)
                begin
                    if ((b == "+" || b == "-") && line_bytes == 0)
                    begin
                        negative = (b == "-");
                        line_bytes = 1;
                        return 1'b0;
                    end
                    if (b >= "0" && b <= "9")
                    begin
                        d = 64'(b - "0");
                        if (acc > (TOP_BIT - d) / 10)
                            acc = TOP_BIT;
                        else
                            acc = acc * 10 + d;
                        line_bytes = 2;
                        return 1'b0;
                    end
                    return fail_res(r);
                end
                if (ph == PH_BOOL && line_bytes == 0
                    && (b == "t" || b == "T" || b == "f" || b == "F"))
                begin
                    acc = (b == "t" || b == "T") ? 64'd1 : 64'd0;
                    line_bytes = 1;
                    return 1'b0;
                end
                return fail_res(r);
            end
            PH_DATA:
            begin
                if (bulk_left > 0)
                    bulk_left--;
                if (bulk_left == 0)
                    ph = PH_TCR;
                if (typ == TY_VERB && verb_idx < 4)
                begin
                    if (verb_idx < 3)
                    begin
                        verb_idx++;
                        r = make_res(resp3_pkg::EV_PAYLOAD, b, 1'b1, 64'd0, 1'b0, 1'b0);
                        return 1'b1;
                    end
                    if (b != ":")
                        return fail_res(r);
                    verb_idx = 4;
                    return 1'b0;
                end
                r = make_res(resp3_pkg::EV_PAYLOAD, b, 1'b0, 64'd0, 1'b0, 1'b0);
                return 1'b1;
            end
            PH_TCR:
            begin
                if (b != 8'h0D)
                    return fail_res(r);
                ph = PH_TLF;
                return 1'b0;
            end
            PH_TLF:
            begin
                if (b != 8'h0A)
                    return fail_res(r);
                return finish_elem((typ == TY_VERB) ? acc - 64'd4 : acc, 1'b0, 64'd0, r);
            end
            default:
            begin
                t = type_code_of(b);
                cr_seen = 1'b0;
                acc = 64'd0;
                negative = 1'b0;
                line_bytes = 0;
                bulk_left = 64'd0;
                verb_idx = 0;
                if (t == TY_BAD)
                begin
                    typ = 4'd0;
                    return fail_res(r);
                end
                typ = t;
                if (t == TY_SIMPLE || t == TY_ERROR || t == TY_DOUBLE)
                    ph = PH_TEXT;
                else if (t == TY_NULL)
                    ph = PH_NULL;
                else if (t == TY_BOOL)
                    ph = PH_BOOL;
                else
                    ph = PH_NUM;
                return 1'b0;
            end
        endcase
    endfunction

    // stream building helpers
    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_q.push_back(s[i]);
    endtask

    task automatic put_crlf();
        byte_q.push_back(8'h0D);
        byte_q.push_back(8'h0A);
    endtask

    task automatic put_line(input string s);
        put_str(s);
        put_crlf();
    endtask

    // random line text: any byte except carriage return
    task automatic put_text(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == 8'h0D);
            byte_q.push_back(b);
        end
    endtask

    task automatic put_data(input int n);
        for (int i = 0; i < n; i++)
            byte_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // random signed decimal, sometimes long enough to saturate
    task automatic put_number();
        int nd;
        case ($urandom_range(0, 3))
            0: put_str("-");
            1: put_str("+");
            default: ;
        endcase
        nd = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 6);
        for (int i = 0; i < nd; i++)
            byte_q.push_back(8'("0" + $urandom_range(0, 9)));
        put_crlf();
    endtask

    task automatic put_len(input int n);
        case ($urandom_range(0, 5))
            0: put_str("+");
            1: put_str("0");
            default: ;
        endcase
        put_line($sformatf("%0d", n));
    endtask

    task automatic put_bulk(input string tc, input int n);
        put_str(tc);
        put_len(n);
        put_data(n);
        put_crlf();
    endtask

    task automatic put_verbatim(input int n);
        put_str("=");
        put_len(n);
        put_data(3);
        put_str(":");
        put_data(n - 4);
        put_crlf();
    endtask

    // one random well-formed element, nested aggregates included
    task automatic gen_element(input int depth);
        int k, n, cnt;
        k = $urandom_range(0, (depth >= 3) ? 9 : 14);
        case (k)
            TY_SIMPLE, TY_ERROR:
            begin
                byte_q.push_back(TYPE_CHARS[k]);
                put_text($urandom_range(0, 6));
                put_crlf();
            end
            TY_DOUBLE:
            begin
                put_str(",");
                put_text($urandom_range(1, 6));
                put_crlf();
            end
            TY_INT, TY_BIGNUM:
            begin
                byte_q.push_back(TYPE_CHARS[k]);
                put_number();
            end
            TY_NULL: put_line("_");
            TY_BOOL:
            begin
                byte_q.push_back("#");
                byte_q.push_back(BOOL_CHARS[$urandom_range(0, 3)]);
                put_crlf();
            end
            TY_BULK, TY_BULKERR:
                if ($urandom_range(0, 7) == 0)
                begin
                    byte_q.push_back(TYPE_CHARS[k]);
                    put_line("-1");
                end
                else
                    put_bulk(string'(8'(TYPE_CHARS[k])), $urandom_range(0, 10));
            TY_VERB: put_verbatim($urandom_range(4, 10));
            default:
            begin
                byte_q.push_back(TYPE_CHARS[k]);
                if (k != TY_ATTR && $urandom_range(0, 7) == 0)
                    put_line("-1");
                else
                begin
                    n = (k == TY_ATTR) ? $urandom_range(1, 2) : $urandom_range(0, 3);
                    put_len(n);
                    cnt = (k == TY_MAP || k == TY_ATTR) ? 2 * n : n;
                    for (int i = 0; i < cnt; i++)
                        gen_element(depth + 1);
                    if (k == TY_ATTR)
                        gen_element(depth + 1);
                end
            end
        endcase
    endtask

    // a single protocol violation; the parser is silent afterwards
    task automatic gen_violation();
        case ($urandom_range(0, 12))
            0: put_str("@");
            1: begin put_str("+ab"); byte_q.push_back(8'h0D); put_str("x"); end
            2: put_line(":12a");
            3: put_line(":-");
            4: put_line(",");
            5: put_line("_x");
            6: put_line("#x");
            7: put_line("$-2");
            8: put_line("$4294967296");
            9: put_line("=3");
            10: begin put_line("=5"); put_str("txt;x"); put_crlf(); end
            11: begin put_line("$2"); put_str("abc"); end
            default:
            begin
                put_line("%4294967295");
                put_line("%4294967295");
                put_line("%4294967295");
            end
        endcase
        put_data($urandom_range(5, 30));
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 65)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sender: one byte per beat from the pending queue, model updated on accept
    always @(posedge clk or negedge rst_n)
    begin
        resp3_pkg::result_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'd0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall && predict_beat(data_byte, r))
                expect_q.push_back(r);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!send_pause && byte_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    data_byte <= byte_q.pop_front();
                    send_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: compare each result beat with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        resp3_pkg::result_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expect_q.size() == 0)
                    report("result beat with nothing expected");
                else
                begin
                    e = expect_q.pop_front();
                    if (event_kind !== e.event_kind)
                        report($sformatf("event_kind %0d, want %0d", event_kind, e.event_kind));
                    if (payload_byte !== e.payload_byte)
                        report($sformatf("payload_byte %h, want %h", payload_byte,
                                         e.payload_byte));
                    if (is_encoding !== e.is_encoding)
                        report($sformatf("is_encoding %b, want %b", is_encoding,
                                         e.is_encoding));
                    if (element_type !== e.element_type)
                        report($sformatf("element_type %0d, want %0d", element_type,
                                         e.element_type));
                    if (element_value !== e.element_value)
                        report($sformatf("element_value %0d, want %0d", element_value,
                                         e.element_value));
                    if (is_null !== e.is_null)
                        report($sformatf("is_null %b, want %b", is_null, e.is_null));
                    if (message_done !== e.message_done)
                        report($sformatf("message_done %b, want %b", message_done,
                                         e.message_done));
                end
            end
            if (long_hold)
                out_stall <= 1'b1;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                recv_gap <= pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and each element kind
        put_line("+OK");
        put_str("-E"); byte_q.push_back(8'h0A); put_str("R"); byte_q.push_back(8'hFF);
        put_crlf();
        put_line(":0");
        put_line(":+9223372036854775807");
        put_line(":-9223372036854775808");
        put_line(":99999999999999999999");
        put_line(":-99999999999999999999");
        put_line("_");
        put_line("#t");
        put_line("#F");
        put_line(",1.5");
        put_line("(-123456789012345678901");
        put_line("$0"); put_crlf();
        put_line("$-0"); put_crlf();
        put_line("$-1");
        put_str("$4"); put_crlf();
        byte_q.push_back(8'h00); byte_q.push_back(8'hFF); byte_q.push_back(8'h0D);
        byte_q.push_back(8'h55); put_crlf();
        put_line("!3"); put_str("bad"); put_crlf();
        put_line("=6"); put_str("txt:ab"); put_crlf();
        put_line("*-1");
        put_line("*0");
        put_line("~2"); put_line("#f"); put_line("_");
        put_line(">1"); put_line(":7");
        put_line("%1"); put_line("+k"); put_line(":1");
        put_line("|1"); put_line("+a"); put_line("+b"); put_line(":5");
        wait (byte_q.size() == 0 && !in_valid);

        // sender pause until every result has come
        send_pause = 1'b1;
        wait (expect_q.size() == 0);
        send_pause = 1'b0;

        // random messages; a long receiver hold-off during the second batch
        for (int batch = 0; batch < 6; batch++)
        begin
            calm = (batch == 2);
            while (byte_q.size() < 170)
                gen_element(0);
            if (batch == 1)
            begin
                repeat (300) @(posedge clk);
                long_hold = 1'b1;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            wait (byte_q.size() == 0 && !in_valid);
        end
        calm = 1'b0;
        gen_violation();
        wait (byte_q.size() == 0 && !in_valid);
        wait (expect_q.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && expect_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/resp3_pkg.sv
hw/rtl/resp3_core.sv
hw/rtl/resp3_stream_parser.sv
dv/resp3_stream_parser_tb.sv
